/* design/okvl_pkg.sv */
// ----------------------------------------------------------------------------
// okvl_pkg
// Shared codes and types for the ordered key/value list unit.
// ----------------------------------------------------------------------------
package okvl_pkg;

  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int ST_W     = 3;
  localparam int POS_W    = 6;
  localparam int COUNT_OW = 6;

  // Operation codes; code 7 is a no-op and has no member
  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_POS   = 3'd5,
    OP_FIND      = 3'd6
  } op_t;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 3'd2;
  localparam logic [ST_W-1:0] ST_DUP    = 3'd3;
  localparam logic [ST_W-1:0] ST_BADPOS = 3'd4;
  localparam logic [ST_W-1:0] ST_MISS   = 3'd5;

  // Per-cell update command
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage

/* design/okvl_in_if.sv */
// ----------------------------------------------------------------------------
// okvl_in_if
// Operation channel: valid/ready handshake with one operation per beat.
// ----------------------------------------------------------------------------
interface okvl_in_if;
  import okvl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [KEY_W-1:0]  entry_key;
  logic signed [KEY_W-1:0]  entry_value;
  logic [POS_W-1:0]         position;

  modport source (output valid, operation, entry_key, entry_value, position, input ready);
  modport sink   (input valid, operation, entry_key, entry_value, position, output ready);
endinterface

/* design/okvl_out_if.sv */
// ----------------------------------------------------------------------------
// okvl_out_if
// Result channel: valid/ready handshake with one result per beat.
// ----------------------------------------------------------------------------
interface okvl_out_if;
  import okvl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [KEY_W-1:0]  result_value;
  logic [COUNT_OW-1:0]      entry_count;

  modport source (output valid, status, result_value, entry_count, input ready);
  modport sink   (input valid, status, result_value, entry_count, output ready);
endinterface

/* design/okvl_cell.sv */
// ----------------------------------------------------------------------------
// okvl_cell
// One list slot: holds a key/value pair, compares its key against the
// broadcast key and loads new data or a neighbor's pair on command.
// ----------------------------------------------------------------------------
module okvl_cell import okvl_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [DATA_WIDTH-1:0] cmp_key,
  input  logic [DATA_WIDTH-1:0] new_key,
  input  logic [DATA_WIDTH-1:0] new_val,
  input  logic [DATA_WIDTH-1:0] left_key,
  input  logic [DATA_WIDTH-1:0] left_val,
  input  logic [DATA_WIDTH-1:0] right_key,
  input  logic [DATA_WIDTH-1:0] right_val,
  output logic [DATA_WIDTH-1:0] key,
  output logic [DATA_WIDTH-1:0] val,
  output logic                  hit
);

  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;

  // Select the next pair for this slot
  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    case (ctrl.op)
      CELL_HOLD: begin
        key_nxt = key_r;
        val_nxt = val_r;
      end
      CELL_LOAD: begin
        key_nxt = new_key;
        val_nxt = new_val;
      end
      CELL_FROM_LEFT: begin
        key_nxt = left_key;
        val_nxt = left_val;
      end
      CELL_FROM_RIGHT: begin
        key_nxt = right_key;
        val_nxt = right_val;
      end
      default: begin
        key_nxt = key_r;
        val_nxt = val_r;
      end
    endcase
  end

  // Hold the pair; no reset, occupancy is tracked by the list count
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

  assign key = key_r;
  assign val = val_r;
  assign hit = (key_r == cmp_key);

endmodule

/* design/ordered_key_value_list_unit.sv */
// An accepted operation beat has its key compared in every cell at once,
// and the matches are registered; the execute state decides, shifts the
// whole cell row and registers the result; then a new beat can be taken.
// Reset clears the entry count and the handshake state; cell contents are
// left as they are and only slots below the count are ever read.
// ----------------------------------------------------------------------------
// ordered_key_value_list_unit
// Ordered list of unique key/value pairs held in a row of shifting cells,
// with insert, remove and find by front, back, position or key.
// ----------------------------------------------------------------------------
module ordered_key_value_list_unit import okvl_pkg::*; #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  okvl_in_if.sink    in_ch,
  okvl_out_if.source out_ch
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                state_r;
  logic [CW-1:0]         count_r;
  logic [OP_W-1:0]       op_r;
  logic [DATA_WIDTH-1:0] key_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [POS_W-1:0]      pos_r;
  logic [CAPACITY-1:0]   match_r;
  logic                  out_valid_r;
  logic [ST_W-1:0]       out_status_r;
  logic [KEY_W-1:0]      out_value_r;
  logic [COUNT_OW-1:0]   out_count_r;

  logic [DATA_WIDTH-1:0] in_key;
  logic [DATA_WIDTH-1:0] in_val;
  logic                  in_fire;
  logic [CAPACITY-1:0]   hit;
  logic [DATA_WIDTH-1:0] cell_key [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_val [CAPACITY];
  cell_ctrl_t            cell_ctrl [CAPACITY];

  logic [CMPW-1:0]       cnt_x;
  logic [CMPW-1:0]       pos_x;
  logic [CMPW-1:0]       tgt;
  logic [ST_W-1:0]       st;
  logic                  do_ins;
  logic                  do_rem;
  logic                  do_find;
  logic signed [DATA_WIDTH-1:0] rd_val;
  logic [KEY_W-1:0]      res_val;
  logic [CW-1:0]         count_nxt;

  // Accept a new beat only between operations and with room at the output
  assign in_ch.ready  = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_key       = DATA_WIDTH'(in_ch.entry_key);
  assign in_val       = DATA_WIDTH'(in_ch.entry_value);

  // Cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] lk, lv, rk, rv;
    if (g == 0) begin : g_first
      assign lk = key_r;
      assign lv = val_r;
    end else begin : g_mid
      assign lk = cell_key[g-1];
      assign lv = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign rk = cell_key[g];
      assign rv = cell_val[g];
    end else begin : g_inner
      assign rk = cell_key[g+1];
      assign rv = cell_val[g+1];
    end

    okvl_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[g]),
      .cmp_key   (in_key),
      .new_key   (key_r),
      .new_val   (val_r),
      .left_key  (lk),
      .left_val  (lv),
      .right_key (rk),
      .right_val (rv),
      .key       (cell_key[g]),
      .val       (cell_val[g]),
      .hit       (hit[g])
    );
  end

  // Decide status and target slot from the registered compare results
  always_comb begin
    cnt_x   = CMPW'(count_r);
    pos_x   = CMPW'(pos_r);
    tgt     = '0;
    st      = ST_OK;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    do_find = 1'b0;
    case (op_r)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
        if (op_r == OP_INS_POS && (pos_x == '0 || pos_x > cnt_x + CMPW'(1))) begin
          st = ST_BADPOS;
        end else if (cnt_x >= CMPW'(CAPACITY)) begin
          st = ST_FULL;
        end else if (|match_r) begin
          st = ST_DUP;
        end else begin
          do_ins = 1'b1;
        end
        if (op_r == OP_INS_FRONT) begin
          tgt = '0;
        end else if (op_r == OP_INS_BACK) begin
          tgt = cnt_x;
        end else begin
          tgt = pos_x - CMPW'(1);
        end
      end
      OP_REM_FRONT, OP_REM_BACK, OP_REM_POS: begin
        if (cnt_x == '0) begin
          st = ST_EMPTY;
        end else if (op_r == OP_REM_POS && (pos_x == '0 || pos_x > cnt_x)) begin
          st = ST_BADPOS;
        end else begin
          do_rem = 1'b1;
        end
        if (op_r == OP_REM_FRONT) begin
          tgt = '0;
        end else if (op_r == OP_REM_BACK) begin
          tgt = cnt_x - CMPW'(1);
        end else begin
          tgt = pos_x - CMPW'(1);
        end
      end
      OP_FIND: begin
        if (|match_r) begin
          do_find = 1'b1;
        end else begin
          st = ST_MISS;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  // Drive per-cell commands and pick the removed or found value
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctrl[i].op = CELL_HOLD;
      if (state_r == S_EXEC && do_ins) begin
        if (CMPW'(i) == tgt) begin
          cell_ctrl[i].op = CELL_LOAD;
        end else if (CMPW'(i) > tgt && CMPW'(i) <= cnt_x) begin
          cell_ctrl[i].op = CELL_FROM_LEFT;
        end
      end else if (state_r == S_EXEC && do_rem) begin
        if (CMPW'(i) >= tgt && CMPW'(i) + CMPW'(1) < cnt_x) begin
          cell_ctrl[i].op = CELL_FROM_RIGHT;
        end
      end
      if ((do_rem && CMPW'(i) == tgt) || (do_find && match_r[i])) begin
        rd_val = rd_val | cell_val[i];
      end
    end
  end

  assign res_val   = (do_rem || do_find) ? KEY_W'(rd_val) : '0;
  assign count_nxt = do_ins ? count_r + CW'(1) : (do_rem ? count_r - CW'(1) : count_r);

  // Sequencer, operand capture and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r      <= S_IDLE;
          count_r      <= count_nxt;
          out_valid_r  <= 1'b1;
          out_status_r <= st;
          out_value_r  <= res_val;
          out_count_r  <= COUNT_OW'(count_nxt);
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
    // Capture the operand beat and the occupied-slot key matches
    if (in_fire) begin
      op_r  <= in_ch.operation;
      key_r <= in_key;
      val_r <= in_val;
      pos_r <= in_ch.position;
      for (int i = 0; i < CAPACITY; i++) begin
        match_r[i] <= hit[i] && (CW'(i) < count_r);
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.entry_count  = out_count_r;

`ifndef SYNTH
  // List never holds more entries than it has cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // An accepted beat moves to execution with the result register empty
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC) && !out_valid_r)
    else $error("accepted beat did not start execution on a free output");

  // Execution always produces a result beat
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> out_valid_r && (state_r == S_IDLE))
    else $error("execution produced no result beat");
`endif

endmodule

/* tb/okvl_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// okvl_result_checker
// Watches the operation and result channels, keeps a shadow copy of the
// list, predicts status, value and count for every operation beat and
// compares each result beat with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module okvl_result_checker import okvl_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic clk,
  input  logic rst_n,
  okvl_in_if   in_mon,
  okvl_out_if  out_mon,
  output int   fail_count,
  output int   results_checked,
  output int   full_rejects,
  output int   results_owed
);

  localparam int OWED_DEPTH = 8;

  typedef struct packed {
    logic [ST_W-1:0]     status;
    logic [KEY_W-1:0]    value;
    logic [COUNT_OW-1:0] count;
  } list_result_t;

  logic [KEY_W-1:0] key_cells   [CAPACITY];
  logic [KEY_W-1:0] value_cells [CAPACITY];
  int               fill_level = 0;
  list_result_t     owed_buf [OWED_DEPTH];
  int               owed_wr = 0;
  int               owed_rd = 0;
  int               owed_level = 0;
  int               errors = 0;
  int               checked = 0;
  int               fulls = 0;
  int               owed_cnt = 0;

  assign fail_count      = errors;
  assign results_checked = checked;
  assign full_rejects    = fulls;
  assign results_owed    = owed_cnt;

  // Slot holding the key, or -1 when absent
  function automatic int slot_of(logic [KEY_W-1:0] key);
    int i;
    for (i = 0; i < fill_level; i++) begin
      if (key_cells[i] == key) return i;
    end
    return -1;
  endfunction

  // Open a gap at slot 'at' and store the pair there
  function automatic void place_entry(int at, logic [KEY_W-1:0] key, logic [KEY_W-1:0] val);
    int i;
    for (i = fill_level; i > at; i--) begin
      key_cells[i]   = key_cells[i-1];
      value_cells[i] = value_cells[i-1];
    end
    key_cells[at]   = key;
    value_cells[at] = val;
    fill_level++;
  endfunction

  // Close the gap left by slot 'at' and hand back its value
  function automatic logic [KEY_W-1:0] take_entry(int at);
    logic [KEY_W-1:0] v;
    int i;
    v = value_cells[at];
    for (i = at; i + 1 < fill_level; i++) begin
      key_cells[i]   = key_cells[i+1];
      value_cells[i] = value_cells[i+1];
    end
    fill_level--;
    return v;
  endfunction

  // Apply one operation to the shadow list and return what the block owes
  function automatic list_result_t apply_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                            logic [KEY_W-1:0] val, logic [POS_W-1:0] pos);
    list_result_t r;
    int slot;
    int p;
    r.status = ST_OK;
    r.value  = '0;
    p = int'(pos);
    case (op)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
        if (op == OP_INS_POS && (p < 1 || p > fill_level + 1)) begin
          r.status = ST_BADPOS;
        end else if (fill_level >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (slot_of(key) >= 0) begin
          r.status = ST_DUP;
        end else if (op == OP_INS_FRONT) begin
          place_entry(0, key, val);
        end else if (op == OP_INS_BACK) begin
          place_entry(fill_level, key, val);
        end else begin
          place_entry(p - 1, key, val);
        end
      end
      OP_REM_FRONT, OP_REM_BACK, OP_REM_POS: begin
        if (fill_level == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_REM_POS && (p < 1 || p > fill_level)) begin
          r.status = ST_BADPOS;
        end else if (op == OP_REM_FRONT) begin
          r.value = take_entry(0);
        end else if (op == OP_REM_BACK) begin
          r.value = take_entry(fill_level - 1);
        end else begin
          r.value = take_entry(p - 1);
        end
      end
      OP_FIND: begin
        slot = slot_of(key);
        if (slot < 0) begin
          r.status = ST_MISS;
        end else begin
          r.value = value_cells[slot];
        end
      end
      default: ;
    endcase
    r.count = fill_level[COUNT_OW-1:0];
    return r;
  endfunction

  task automatic flag(string what, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
    errors++;
    $display("%0t: %s mismatch on result %0d: expected %0h, actual %0h",
             $time, what, checked, want, got);
  endtask

  // Predict on every operation beat, compare on every result beat
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        if (owed_level >= OWED_DEPTH) begin
          errors++;
          $display("%0t: too many results owed: expected at most %0d, actual %0d",
                   $time, OWED_DEPTH, owed_level + 1);
        end else begin
          owed_buf[owed_wr] = apply_op(in_mon.operation, in_mon.entry_key,
                                       in_mon.entry_value, in_mon.position);
          owed_wr = (owed_wr + 1) % OWED_DEPTH;
          owed_level++;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (owed_level == 0) begin
          errors++;
          $display("%0t: unexpected result beat: expected none, actual status %0d",
                   $time, out_mon.status);
          $display("%0t:   value %0h count %0d",
                   $time, out_mon.result_value, out_mon.entry_count);
        end else begin
          want = owed_buf[owed_rd];
          owed_rd = (owed_rd + 1) % OWED_DEPTH;
          owed_level--;
          if (out_mon.status !== want.status) flag("status", want.status, out_mon.status);
          if (out_mon.result_value !== want.value) flag("value", want.value, out_mon.result_value);
          if (out_mon.entry_count !== want.count) flag("count", want.count, out_mon.entry_count);
          if (want.status == ST_FULL) fulls++;
          checked++;
        end
      end
      owed_cnt <= owed_level;
    end
  end

endmodule

/* tb/ordered_key_value_list_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_key_value_list_unit_tb
// Drives directed corner cases and then random fill/drain runs of list
// operations through the block under four flow-control mixes; the checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module ordered_key_value_list_unit_tb import okvl_pkg::*;;

  localparam logic [OP_W-1:0] OP_NOP = 3'd7;
  localparam int PHASE_ITEMS  = 425;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int POOL_SIZE    = 48;

  logic clk;
  logic rst_n;
  int   sender_idle_pct    = 0;
  int   receiver_stall_pct = 0;
  int   sent               = 0;
  int   quiet_cycles       = 0;
  int   fail_count;
  int   results_checked;
  int   full_rejects;
  int   results_owed;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  okvl_in_if  in_ch ();
  okvl_out_if out_ch ();

  ordered_key_value_list_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  okvl_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .results_checked (results_checked),
    .full_rejects    (full_rejects),
    .results_owed    (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: stall at random
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Watchdog: abort when no beat moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Idle at random, then hold one operation beat until it is taken
  task automatic send_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                         logic [KEY_W-1:0] val, logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.entry_key   <= key;
    in_ch.entry_value <= val;
    in_ch.position    <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Insert-heavy mix while filling, remove-heavy mix while draining
  function automatic logic [OP_W-1:0] pick_op(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return OP_NOP;
    if (filling) begin
      if (r < 24) return OP_INS_FRONT;
      if (r < 46) return OP_INS_BACK;
      if (r < 72) return OP_INS_POS;
      if (r < 76) return OP_REM_FRONT;
      if (r < 80) return OP_REM_BACK;
      if (r < 85) return OP_REM_POS;
      return OP_FIND;
    end
    if (r < 7)  return OP_INS_FRONT;
    if (r < 12) return OP_INS_BACK;
    if (r < 17) return OP_INS_POS;
    if (r < 35) return OP_REM_FRONT;
    if (r < 53) return OP_REM_BACK;
    if (r < 80) return OP_REM_POS;
    return OP_FIND;
  endfunction

  // Mostly pooled keys so duplicates and find hits are common
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [KEY_W-1:0] pick_value();
    case ($urandom_range(0, 39))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Short lists need small positions; keep some out-of-range ones too
  function automatic logic [POS_W-1:0] pick_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return POS_W'($urandom_range(0, 4));
    if (r < 85) return POS_W'($urandom_range(0, 34));
    return POS_W'($urandom_range(0, 63));
  endfunction

  initial begin
    int  phase;
    int  n;
    int  segment_left;
    bit  filling;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_NOP;
    in_ch.entry_key   <= '0;
    in_ch.entry_value <= '0;
    in_ch.position    <= '0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (n = 4; n < POOL_SIZE; n++) key_pool[n] = $urandom;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list errors, no-op, bad positions, extremes, duplicates
    send_op(OP_REM_FRONT, 32'h0, 32'h0, 6'd0);
    send_op(OP_REM_BACK,  32'h0, 32'h0, 6'd0);
    send_op(OP_REM_POS,   32'h0, 32'h0, 6'd1);
    send_op(OP_FIND,      32'h0, 32'h0, 6'd0);
    send_op(OP_NOP,       32'hffff_ffff, 32'hffff_ffff, 6'd63);
    send_op(OP_INS_POS,   32'h1, 32'h1, 6'd0);
    send_op(OP_INS_POS,   32'h1, 32'h1, 6'd2);
    send_op(OP_INS_POS,   32'h8000_0000, 32'h7fff_ffff, 6'd1);
    send_op(OP_INS_FRONT, 32'h7fff_ffff, 32'h8000_0000, 6'd0);
    send_op(OP_INS_BACK,  32'h0000_0000, 32'hffff_ffff, 6'd0);
    send_op(OP_INS_BACK,  32'hffff_ffff, 32'h0000_0000, 6'd0);
    send_op(OP_INS_FRONT, 32'h0000_0000, 32'h1234_5678, 6'd0);
    send_op(OP_INS_POS,   32'h5, 32'h55, 6'd3);
    send_op(OP_INS_POS,   32'h6, 32'h66, 6'd6);
    send_op(OP_INS_POS,   32'h7, 32'h77, 6'd63);
    send_op(OP_INS_POS,   32'h5, 32'h99, 6'd2);
    send_op(OP_FIND,      32'h8000_0000, 32'h0, 6'd0);
    send_op(OP_FIND,      32'h0001_2345, 32'h0, 6'd0);
    send_op(OP_REM_POS,   32'h0, 32'h0, 6'd0);
    send_op(OP_REM_POS,   32'h0, 32'h0, 6'd7);
    send_op(OP_REM_POS,   32'h0, 32'h0, 6'd3);
    send_op(OP_REM_FRONT, 32'h0, 32'h0, 6'd0);
    send_op(OP_REM_BACK,  32'h0, 32'h0, 6'd0);

    // Random fill/drain runs under each flow-control mix
    segment_left = 0;
    filling      = 1'b0;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
        default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (segment_left == 0) begin
          filling      = !filling;
          segment_left = filling ? $urandom_range(50, 90) : $urandom_range(30, 70);
        end
        segment_left--;
        if ($urandom_range(0, 99) < 10) begin
          send_op(OP_W'($urandom_range(0, 7)), $urandom, $urandom,
                  POS_W'($urandom_range(0, 63)));
        end else begin
          send_op(pick_op(filling), pick_key(), pick_value(), pick_pos());
        end
      end
    end
    in_ch.valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d operation beats: corner cases, then fill/drain runs with noise,",
             sent);
    $display("under four flow-control mixes.");
    $display("Checked %0d result beats, %0d of them full-list rejections.",
             results_checked, full_rejects);
    if (fail_count == 0 && results_owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
